FILE: sv/c8x_pkg.sv
package c8x_pkg;

	localparam int MIX_ROUNDS = 8;
	localparam int RND_W = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
	localparam int KEY_REGS = 4;
	localparam int CFG_IDX_W = 8;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] block_t;
	typedef logic [KEY_REGS-1:0][63:0] key_t;

	typedef enum logic [1:0] {
		FUNC_XOR   = 2'd0,
		FUNC_SEAL  = 2'd1,
		FUNC_CHECK = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam logic [3:0] LAST_WORD_FIRST = 4'd13;
	localparam logic [3:0] LAST_WORD = 4'd15;
	localparam logic [2:0] WORD_BYTES = 3'd4;

	localparam word_t BASE_WORDS [12] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13
	};

	// word index of one role (a, b, c, d) of a quarter-round lane
	function automatic logic [3:0] qr_index(input logic diag, input logic [1:0] lane,
			input logic [1:0] role);
		logic [1:0] col;
		col = lane + (diag ? role : 2'd0);
		return {role, col};
	endfunction

	// rotate amounts of the four add-xor-rotate steps
	function automatic word_t rotl_step(input word_t v, input logic [1:0] step);
		word_t r;
		case (step)
			2'd0: r = {v[15:0], v[31:16]};
			2'd1: r = {v[19:0], v[31:20]};
			2'd2: r = {v[23:0], v[31:24]};
			2'd3: r = {v[24:0], v[31:25]};
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/c8x_ifs.sv
interface c8x_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic        start_req;
	logic [63:0] iv;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic [63:0] mac_value;
	logic [63:0] received_tag;

	modport source (output valid, func, start_req, iv, data_word, valid_bytes, mac_value,
		received_tag, input ready);
	modport sink (input valid, func, start_req, iv, data_word, valid_bytes, mac_value,
		received_tag, output ready);
endinterface

interface c8x_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_out;
	logic [63:0] tag_out;
	logic        tag_ok;

	modport source (output valid, data_out, tag_out, tag_ok, input ready);
	modport sink (input valid, data_out, tag_out, tag_ok, output ready);
endinterface

interface c8x_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [c8x_pkg::CFG_IDX_W-1:0] index;
	logic [63:0]                   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/c8x_core.sv
module c8x_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  c8x_pkg::key_t     key,
	input  logic [63:0]       counter,
	input  logic [63:0]       nonce,
	output c8x_pkg::block_t   ks,
	output logic              done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic [c8x_pkg::RND_W-1:0]   round_q;
	logic [1:0]                  step_q;
	c8x_pkg::block_t             w_q;
	c8x_pkg::block_t             w_d;
	c8x_pkg::block_t             init;
	c8x_pkg::block_t             fin;
	logic                        last_step;

	always_comb begin
		for (int i = 0; i < 12; i++) begin
			init[i] = c8x_pkg::BASE_WORDS[i];
		end
		for (int i = 0; i < 8; i++) begin
			init[i] = init[i] ^ ((i % 2 == 1) ? key[i / 2][63:32] : key[i / 2][31:0]);
		end
		init[12] = counter[31:0];
		init[13] = counter[63:32];
		init[14] = nonce[31:0];
		init[15] = nonce[63:32];
		for (int i = 0; i < 16; i++) begin
			fin[i] = w_q[i] + init[i];
		end
	end

	// four lanes do one add-xor-rotate step of their quarter round per cycle
	always_comb begin
		logic [3:0]     ix;
		logic [3:0]     iy;
		logic [3:0]     iz;
		c8x_pkg::word_t sum;
		w_d = w_q;
		for (int l = 0; l < 4; l++) begin
			ix = c8x_pkg::qr_index(round_q[0], 2'(l), step_q[0] ? 2'd2 : 2'd0);
			iy = c8x_pkg::qr_index(round_q[0], 2'(l), step_q[0] ? 2'd3 : 2'd1);
			iz = c8x_pkg::qr_index(round_q[0], 2'(l), step_q[0] ? 2'd1 : 2'd3);
			sum = w_q[ix] + w_q[iy];
			w_d[ix] = sum;
			w_d[iz] = c8x_pkg::rotl_step(w_q[iz] ^ sum, step_q);
		end
	end

	assign last_step = (round_q == c8x_pkg::RND_W'(c8x_pkg::MIX_ROUNDS - 1)) &&
		(step_q == 2'd3);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD:  w_q <= init;
			ST_ROUND: w_q <= w_d;
			default:  w_q <= w_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			step_q <= '0;
			ks <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					round_q <= '0;
					step_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						round_q <= round_q + c8x_pkg::RND_W'(1);
					end
					if (last_step) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					ks <= fin;
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("block generation started while busy");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> round_q <= c8x_pkg::RND_W'(c8x_pkg::MIX_ROUNDS - 1))
		else $error("round count overran");
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("done without final add");
`endif

endmodule

FILE: sv/chacha8_stream_xor_with_tag_mask.sv
// stream cipher unit: xors message words with a chacha-style keystream and masks a 64-bit tag
// cfg: write the four 64-bit key registers (index 0..3) while no item is in flight;
//   other indexes are ignored, cfg is always ready
// item_in: one item per command; start_req=1 latches iv, clears the block counter
//   and word position and builds block 0 before func acts
// item_out: one item per input item, held in an output register until taken
// func 0 xors data_word, func 1 gives mac_value ^ mask, func 2 checks the received tag
// item steps: the item is accepted, then the result register is loaded;
//   each block build keeps ready low while the core loads, runs its rounds and adds
//   the starting words, after a start and after the last word of each block
// ready stays low while an item is being worked on or a block is being built
// if item_out is stalled, the result waits in the output register and the next item
//   is taken, but its result is held back until the register is free
// reset clears keys, keystream, counter, position, nonce and mask to zero
module chacha8_stream_xor_with_tag_mask (
	input  logic        clk,
	input  logic        arst_n,
	c8x_cfg_if.sink     cfg,
	c8x_in_if.sink      item_in,
	c8x_out_if.source   item_out
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GEN_START,
		ST_EXEC,
		ST_GEN_NEXT
	} state_t;

	state_t                  state_q;
	c8x_pkg::key_t           key_q;
	logic [63:0]             counter_q;
	logic [3:0]              pos_q;
	logic [63:0]             nonce_q;
	logic [63:0]             tag_mask_q;
	logic                    kick_q;
	logic                    out_valid_q;
	logic [31:0]             data_out_q;
	logic [63:0]             tag_out_q;
	logic                    tag_ok_q;

	logic [1:0]              func_q;
	logic [31:0]             data_word_q;
	logic [2:0]              valid_bytes_q;
	logic [63:0]             mac_q;
	logic [63:0]             rtag_q;

	c8x_pkg::block_t         ks;
	logic                    core_done;
	logic                    in_acc;
	logic                    out_free;
	logic [2:0]              nbytes;
	logic [31:0]             byte_mask;
	logic [31:0]             data_res;
	logic [63:0]             tag_res;
	logic                    ok_res;
	logic                    advance;
	logic                    block_end;

	c8x_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (kick_q),
		.key     (key_q),
		.counter (counter_q),
		.nonce   (nonce_q),
		.ks      (ks),
		.done    (core_done)
	);

	assign cfg.ready = 1'b1;
	assign item_in.ready = (state_q == ST_IDLE);
	assign in_acc = item_in.valid && item_in.ready;
	assign out_free = !out_valid_q || item_out.ready;

	assign item_out.valid = out_valid_q;
	assign item_out.data_out = data_out_q;
	assign item_out.tag_out = tag_out_q;
	assign item_out.tag_ok = tag_ok_q;

	always_comb begin
		nbytes = (valid_bytes_q > c8x_pkg::WORD_BYTES) ? c8x_pkg::WORD_BYTES : valid_bytes_q;
		for (int b = 0; b < 4; b++) begin
			byte_mask[b*8 +: 8] = (3'(b) < nbytes) ? 8'hff : 8'h00;
		end
		data_res = '0;
		tag_res = '0;
		ok_res = 1'b0;
		advance = 1'b0;
		case (func_q)
			c8x_pkg::FUNC_XOR: begin
				data_res = (data_word_q ^ ks[pos_q]) & byte_mask;
				advance = (nbytes != 3'd0);
			end
			c8x_pkg::FUNC_SEAL: tag_res = mac_q ^ tag_mask_q;
			c8x_pkg::FUNC_CHECK: ok_res = ((rtag_q ^ mac_q ^ tag_mask_q) == 64'd0);
			default: begin
				data_res = '0;
			end
		endcase
		// block 0 leaves its top two words for the tag mask
		block_end = (pos_q >= ((counter_q == 64'd0) ? c8x_pkg::LAST_WORD_FIRST
			: c8x_pkg::LAST_WORD));
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= item_in.func;
			data_word_q <= item_in.data_word;
			valid_bytes_q <= item_in.valid_bytes;
			mac_q <= item_in.mac_value;
			rtag_q <= item_in.received_tag;
		end
		if (state_q == ST_EXEC && out_free) begin
			data_out_q <= data_res;
			tag_out_q <= tag_res;
			tag_ok_q <= ok_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg.valid && cfg.ready &&
				cfg.index < c8x_pkg::CFG_IDX_W'(c8x_pkg::KEY_REGS)) begin
			key_q[cfg.index[1:0]] <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			counter_q <= '0;
			pos_q <= '0;
			nonce_q <= '0;
			tag_mask_q <= '0;
			kick_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			kick_q <= 1'b0;
			if (item_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (item_in.start_req) begin
							nonce_q <= item_in.iv;
							counter_q <= '0;
							pos_q <= '0;
							kick_q <= 1'b1;
							state_q <= ST_GEN_START;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_GEN_START: begin
					if (core_done) begin
						tag_mask_q <= {ks[15], ks[14]};
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
						if (advance) begin
							if (block_end) begin
								counter_q <= counter_q + 64'd1;
								pos_q <= '0;
								kick_q <= 1'b1;
								state_q <= ST_GEN_NEXT;
							end else begin
								pos_q <= pos_q + 4'd1;
							end
						end
					end
				end
				ST_GEN_NEXT: begin
					if (core_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_first_block: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q == 64'd0 |-> pos_q <= c8x_pkg::LAST_WORD_FIRST)
		else $error("word position beyond end of block 0");
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result loaded outside execute");
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		core_done |-> (state_q == ST_GEN_START || state_q == ST_GEN_NEXT))
		else $error("block finished while not waiting for it");
`endif

endmodule

FILE: tb/sv/c8x_stream_checker.sv
`timescale 1ns / 1ps

module c8x_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	c8x_cfg_if          cfg,
	c8x_in_if           item_in,
	c8x_out_if          item_out,
	output int          errors,
	output int          pending,
	output logic [63:0] mask_now
);
	import c8x_pkg::*;

	typedef struct packed {
		logic [31:0] data_out;
		logic [63:0] tag_out;
		logic        tag_ok;
	} cipher_res_t;

	typedef logic [15:0][31:0] ks_block_t;

	logic [KEY_REGS-1:0][63:0] key_r;
	ks_block_t                 ks_r;
	logic [63:0]               ctr_r;
	logic [3:0]                pos_r;
	logic [63:0]               nonce_r;
	logic [63:0]               mask_r;
	cipher_res_t               due_results [$];

	cipher_res_t exp_r;
	int          err_cnt = 0;
	int          nbytes;
	logic [31:0] byte_mask;
	logic [3:0]  last_pos;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [127:0] quarter(input logic [31:0] a_in, b_in, c_in, d_in);
		logic [31:0] a, b, c, d;
		a = a_in;
		b = b_in;
		c = c_in;
		d = d_in;
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		return {a, b, c, d};
	endfunction

	// keystream block: mixed words plus the starting words
	function automatic ks_block_t chacha_block(input logic [KEY_REGS-1:0][63:0] key,
			input logic [63:0] ctr, input logic [63:0] nonce);
		logic [31:0]  init [16];
		logic [31:0]  w [16];
		logic [127:0] q;
		int           ia, ib, ic, id;
		ks_block_t    blk;
		for (int i = 0; i < 12; i++)
			init[i] = BASE_WORDS[i];
		for (int i = 0; i < 8; i++)
			init[i] = init[i] ^ key[i >> 1][(i & 1) * 32 +: 32];
		init[12] = ctr[31:0];
		init[13] = ctr[63:32];
		init[14] = nonce[31:0];
		init[15] = nonce[63:32];
		w = init;
		for (int r = 0; r < MIX_ROUNDS; r++) begin
			for (int lane = 0; lane < 4; lane++) begin
				ia = lane;
				if (r % 2 == 0) begin
					ib = 4 + lane;
					ic = 8 + lane;
					id = 12 + lane;
				end else begin
					ib = 4 + (lane + 1) % 4;
					ic = 8 + (lane + 2) % 4;
					id = 12 + (lane + 3) % 4;
				end
				q = quarter(w[ia], w[ib], w[ic], w[id]);
				{w[ia], w[ib], w[ic], w[id]} = q;
			end
		end
		for (int i = 0; i < 16; i++)
			blk[i] = w[i] + init[i];
		return blk;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_r = '0;
			ks_r = '0;
			ctr_r = '0;
			pos_r = '0;
			nonce_r = '0;
			mask_r = '0;
			due_results.delete();
			pending <= 0;
			mask_now <= '0;
			errors <= err_cnt;
		end else begin
			// results first: an item taken on this edge cannot have its result yet
			if (item_out.valid && item_out.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with none expected: data_out %h tag_out %h tag_ok %b",
						$time, item_out.data_out, item_out.tag_out, item_out.tag_ok);
					err_cnt++;
				end else begin
					exp_r = due_results.pop_front();
					if (item_out.data_out !== exp_r.data_out) begin
						$display("%0t: data_out expected %h got %h",
							$time, exp_r.data_out, item_out.data_out);
						err_cnt++;
					end
					if (item_out.tag_out !== exp_r.tag_out) begin
						$display("%0t: tag_out expected %h got %h",
							$time, exp_r.tag_out, item_out.tag_out);
						err_cnt++;
					end
					if (item_out.tag_ok !== exp_r.tag_ok) begin
						$display("%0t: tag_ok expected %b got %b",
							$time, exp_r.tag_ok, item_out.tag_ok);
						err_cnt++;
					end
				end
			end

			if (cfg.valid && cfg.ready && cfg.index < KEY_REGS)
				key_r[cfg.index] = cfg.data;

			if (item_in.valid && item_in.ready) begin
				if (item_in.start_req) begin
					nonce_r = item_in.iv;
					ctr_r = '0;
					pos_r = '0;
					ks_r = chacha_block(key_r, ctr_r, nonce_r);
					mask_r = {ks_r[15], ks_r[14]};
				end
				exp_r = '0;
				case (func_t'(item_in.func))
					FUNC_XOR: begin
						nbytes = (item_in.valid_bytes > WORD_BYTES) ? 4 : int'(item_in.valid_bytes);
						if (nbytes > 0) begin
							byte_mask = (nbytes == 4) ? '1 : ((32'd1 << (8 * nbytes)) - 32'd1);
							exp_r.data_out = (item_in.data_word ^ ks_r[pos_r]) & byte_mask;
							// block 0 keeps words 14 and 15 for the tag mask
							last_pos = (ctr_r == 0) ? LAST_WORD_FIRST : LAST_WORD;
							if (pos_r >= last_pos) begin
								ctr_r = ctr_r + 64'd1;
								pos_r = '0;
								ks_r = chacha_block(key_r, ctr_r, nonce_r);
							end else begin
								pos_r = pos_r + 4'd1;
							end
						end
					end
					FUNC_SEAL: exp_r.tag_out = item_in.mac_value ^ mask_r;
					FUNC_CHECK:
						exp_r.tag_ok = ((item_in.received_tag ^ item_in.mac_value ^ mask_r) == '0);
					default: ;
				endcase
				due_results.push_back(exp_r);
			end

			pending <= due_results.size();
			mask_now <= mask_r;
			errors <= err_cnt;
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import c8x_pkg::*;

	localparam int SETTLE_CYCLES = 4 * MIX_ROUNDS + 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_0_1    = 0,
		REG_KEY_2_3    = 1,
		REG_KEY_4_5    = 2,
		REG_KEY_6_7    = 3,
		REG_SPARE      = 4,
		REG_SPARE_HIGH = {CFG_IDX_W{1'b1}}
	} key_reg_t;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          no_idle;
	int          items_sent;
	int          errors;
	int          pending;
	logic [63:0] mask_now;

	c8x_cfg_if cfg ();
	c8x_in_if  item_in ();
	c8x_out_if item_out ();

	chacha8_stream_xor_with_tag_mask dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.item_in  (item_in),
		.item_out (item_out)
	);

	c8x_stream_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.item_in  (item_in),
		.item_out (item_out),
		.errors   (errors),
		.pending  (pending),
		.mask_now (mask_now)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (no_idle || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver stalls
	initial begin
		int n;
		item_out.ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				item_out.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			item_out.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	task automatic send_item(input func_t f, input bit st, input logic [63:0] iv,
			input logic [31:0] data, input logic [2:0] vb, input logic [63:0] mac,
			input logic [63:0] rtag);
		int n;
		item_in.valid <= 1'b1;
		item_in.func <= f;
		item_in.start_req <= st;
		item_in.iv <= iv;
		item_in.data_word <= data;
		item_in.valid_bytes <= vb;
		item_in.mac_value <= mac;
		item_in.received_tag <= rtag;
		do @(posedge clk); while (!item_in.ready);
		items_sent++;
		n = pick_gap();
		if (n > 0) begin
			item_in.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// wait for every result, then for any block build still running
	task automatic drain();
		item_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_keys(input logic [63:0] k01, k23, k45, k67, input key_reg_t spare);
		key_reg_t    idx [5];
		logic [63:0] val [5];
		idx = '{spare, REG_KEY_0_1, REG_KEY_2_3, REG_KEY_4_5, REG_KEY_6_7};
		val = '{rand64(), k01, k23, k45, k67};
		foreach (idx[i]) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data <= val[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
	endtask

	// start, data words, seal, then verify the sealed tag
	task automatic run_message();
		logic [63:0] iv, mac, rtag;
		logic [2:0]  vb;
		int          words, roll;
		roll = $urandom_range(99);
		words = (roll < 70) ? $urandom_range(0, 16) :
			(roll < 90) ? $urandom_range(17, 45) : $urandom_range(46, 80);
		roll = $urandom_range(9);
		iv = (roll == 0) ? '0 : (roll == 1) ? '1 : rand64();
		if ($urandom_range(3) != 0)
			send_item(FUNC_XOR, 1'b1, iv, $urandom, WORD_BYTES, rand64(), rand64());
		else
			send_item(func_t'($urandom_range(1, 3)), 1'b1, iv, $urandom,
				3'($urandom_range(7)), rand64(), rand64());
		for (int i = 0; i < words; i++) begin
			// stray item: odd widths, unused code, early seal or check, or a fresh start
			if ($urandom_range(19) == 0)
				send_item(func_t'($urandom_range(3)), $urandom_range(9) == 0, rand64(),
					$urandom, 3'($urandom_range(7)), rand64(), rand64());
			vb = (i == words - 1 && $urandom_range(2) == 0) ?
				3'($urandom_range(1, 3)) : WORD_BYTES;
			send_item(FUNC_XOR, 1'b0, rand64(), $urandom, vb, rand64(), rand64());
		end
		mac = rand64();
		send_item(FUNC_SEAL, 1'b0, rand64(), $urandom, 3'($urandom_range(7)), mac, rand64());
		// the last start was taken on an earlier edge, so mask_now is settled
		rtag = mac ^ mask_now;
		roll = $urandom_range(9);
		if (roll == 7 || roll == 8)
			rtag[$urandom_range(63)] ^= 1'b1;
		else if (roll == 9)
			rtag = rand64();
		send_item(FUNC_CHECK, 1'b0, rand64(), $urandom, 3'($urandom_range(7)), mac, rtag);
	endtask

	initial begin
		arst_n <= 1'b0;
		no_idle <= 1'b0;
		items_sent = 0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		item_in.valid <= 1'b0;
		item_in.func <= FUNC_XOR;
		item_in.start_req <= 1'b0;
		item_in.iv <= '0;
		item_in.data_word <= '0;
		item_in.valid_bytes <= '0;
		item_in.mac_value <= '0;
		item_in.received_tag <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no start since reset: zero keystream and zero mask
		send_item(FUNC_XOR, 1'b0, '0, '1, WORD_BYTES, '0, '0);
		send_item(FUNC_SEAL, 1'b0, '1, '0, 3'd0, '1, '0);
		send_item(FUNC_CHECK, 1'b0, '0, '1, 3'd7, '1, '1);
		send_item(FUNC_NONE, 1'b0, '1, '1, 3'd7, '1, '1);
		drain();

		load_keys('1, '1, '1, '1, REG_SPARE_HIGH);
		send_item(FUNC_XOR, 1'b1, '1, '0, WORD_BYTES, '0, '0);
		send_item(FUNC_XOR, 1'b0, '0, '1, 3'd1, '1, '1);
		send_item(FUNC_XOR, 1'b0, '0, '1, 3'd2, '0, '0);
		send_item(FUNC_XOR, 1'b0, '0, '1, 3'd3, '0, '0);
		// zero width does not advance, widths above four act as four
		send_item(FUNC_XOR, 1'b0, '0, '1, 3'd0, '0, '0);
		send_item(FUNC_XOR, 1'b0, '0, '1, 3'd7, '0, '0);
		send_item(FUNC_XOR, 1'b0, '0, '0, 3'd5, '0, '0);
		send_item(FUNC_SEAL, 1'b0, '0, '0, WORD_BYTES, '0, '0);
		send_item(FUNC_CHECK, 1'b0, '0, '0, WORD_BYTES, '0, mask_now);
		send_item(FUNC_CHECK, 1'b0, '0, '0, WORD_BYTES, '0, '1);
		send_item(FUNC_SEAL, 1'b1, '0, '1, WORD_BYTES, '1, '0);
		send_item(FUNC_CHECK, 1'b1, rand64(), '0, WORD_BYTES, '1, '1);
		send_item(FUNC_NONE, 1'b1, rand64(), '1, WORD_BYTES, '1, '1);
		send_item(FUNC_XOR, 1'b1, '0, '0, WORD_BYTES, '0, '0);

		for (int phase = 0; phase < 3; phase++) begin
			drain();
			if (phase == 1)
				load_keys('0, '0, '0, '0, REG_SPARE);
			else
				load_keys(rand64(), rand64(), rand64(), rand64(), REG_SPARE);
			while (items_sent < 18 + 240 * (phase + 1)) begin
				no_idle <= ($urandom_range(6) == 0);
				run_message();
			end
		end
		no_idle <= 1'b0;
		drain();

		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
sv/c8x_pkg.sv
sv/c8x_ifs.sv
sv/c8x_core.sv
sv/chacha8_stream_xor_with_tag_mask.sv
tb/sv/c8x_stream_checker.sv
tb/sv/tb.sv
